// ----- rtl/u8dec_pkg.sv -----
// shared types and constants of the utf-8 stream decoder
package u8dec_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned LenW    = 3;
  localparam int unsigned PayW    = 7;
  localparam int unsigned ContW   = 6;
  localparam int unsigned LeftW   = 2;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = 1;
  localparam int unsigned QCntW   = 2;

  // lead byte prefixes, tested on the top bits
  localparam logic [2:0] Lead2Pfx = 3'h6;
  localparam logic [3:0] Lead3Pfx = 4'hE;
  localparam logic [4:0] Lead4Pfx = 5'h1E;

  // payload masks
  localparam logic [PayW-1:0] Lead2Mask = 7'h1F;
  localparam logic [PayW-1:0] Lead3Mask = 7'h0F;
  localparam logic [PayW-1:0] Lead4Mask = 7'h07;
  localparam logic [PayW-1:0] ContMask  = 7'h3F;

  typedef enum logic [1:0] {
    KIND_LEAD = 2'd0,
    KIND_CONT = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  // one classified byte as it travels from front to back
  typedef struct packed {
    kind_e             kind;
    logic [PayW-1:0]   payload;
    logic [LenW-1:0]   seq_len;
    logic              last;
  } item_t;

endpackage

// ----- rtl/u8dec_front.sv -----
// front end: tracks continuation count and classifies each byte
module u8dec_front
  import u8dec_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] byte_i,
  output item_t            item_o
);

  logic [LeftW-1:0] left_q, left_d;

  always_comb begin
    item_o = '{kind: KIND_BAD, payload: '0, seq_len: '0, last: 1'b1};
    left_d = left_q;
    if (left_q != '0) begin
      item_o.kind    = KIND_CONT;
      item_o.payload = byte_i[PayW-1:0] & ContMask;
      item_o.last    = (left_q == LeftW'(1));
      left_d         = left_q - LeftW'(1);
    end else if (byte_i[7] == 1'b0) begin
      item_o.kind    = KIND_LEAD;
      item_o.payload = byte_i[PayW-1:0];
      item_o.seq_len = LenW'(1);
      item_o.last    = 1'b1;
    end else if (byte_i[7:5] == Lead2Pfx) begin
      item_o.kind    = KIND_LEAD;
      item_o.payload = byte_i[PayW-1:0] & Lead2Mask;
      item_o.seq_len = LenW'(2);
      item_o.last    = 1'b0;
      left_d         = LeftW'(1);
    end else if (byte_i[7:4] == Lead3Pfx) begin
      item_o.kind    = KIND_LEAD;
      item_o.payload = byte_i[PayW-1:0] & Lead3Mask;
      item_o.seq_len = LenW'(3);
      item_o.last    = 1'b0;
      left_d         = LeftW'(2);
    end else if (byte_i[7:3] == Lead4Pfx) begin
      item_o.kind    = KIND_LEAD;
      item_o.payload = byte_i[PayW-1:0] & Lead4Mask;
      item_o.seq_len = LenW'(4);
      item_o.last    = 1'b0;
      left_d         = LeftW'(3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (accept_i) begin
      left_q <= left_d;
    end
  end

endmodule

// ----- rtl/u8dec_fifo.sv -----
// short queue of classified bytes between front and back
module u8dec_fifo
  import u8dec_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/u8dec_back.sv -----
// back end: accumulates payload bits and holds the result register
module u8dec_back
  import u8dec_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  item_t           item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CpW-1:0]  cp_o,
  output logic [LenW-1:0] len_o,
  output logic            bad_o
);

  logic [CpW-1:0]  acc_q, acc_d;
  logic [LenW-1:0] len_q, len_d;
  logic            vld_q, vld_d;
  logic [CpW-1:0]  cp_q, cp_d;
  logic [LenW-1:0] olen_q, olen_d;
  logic            bad_q, bad_d;
  logic            slot_free;

  assign slot_free = !vld_q || out_ready_i;
  // items that produce no word never wait on the output side
  assign pop_o     = valid_i && (!item_i.last || slot_free);

  always_comb begin
    acc_d  = acc_q;
    len_d  = len_q;
    cp_d   = cp_q;
    olen_d = olen_q;
    bad_d  = bad_q;
    case (item_i.kind)
      KIND_LEAD: begin
        acc_d  = CpW'(item_i.payload);
        len_d  = item_i.seq_len;
        cp_d   = CpW'(item_i.payload);
        olen_d = item_i.seq_len;
        bad_d  = 1'b0;
      end
      KIND_CONT: begin
        acc_d  = {acc_q[CpW-ContW-1:0], item_i.payload[ContW-1:0]};
        cp_d   = acc_d;
        olen_d = len_q;
        bad_d  = 1'b0;
      end
      default: begin
        cp_d   = '0;
        olen_d = '0;
        bad_d  = 1'b1;
      end
    endcase
    vld_d = (vld_q && !out_ready_i) || (pop_o && item_i.last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      acc_q <= acc_d;
      len_q <= len_d;
    end
    if (pop_o && item_i.last) begin
      cp_q   <= cp_d;
      olen_q <= olen_d;
      bad_q  <= bad_d;
    end
  end

  assign out_valid_o = vld_q;
  assign cp_o        = cp_q;
  assign len_o       = olen_q;
  assign bad_o       = bad_q;

endmodule

// ----- rtl/utf8_stream_decoder_top.sv -----
// top level of the utf-8 stream decoder
//
// channel   dir  tdata                              tuser
// s_axis    in   [7:0] data_byte                    -
// m_axis    out  [20:0] char_code, [23:21] length   [0] bad_lead
//
// one byte word per cycle sustained while the output is not stalled; the front
// classifies a byte in the cycle it is accepted, and the back folds it into
// the accumulator once it leaves the two-entry queue between them
// a final byte is registered in the queue, its result word in the output register
// reset clears the continuation count, the queue and the output valid
// output stalls back up through the queue; lead and middle bytes keep
// flowing while a finished word waits in the output register
module utf8_stream_decoder_top
  import u8dec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [20:0] char_code, [23:21] char_length
  output logic        m_axis_tuser_o    // [0] bad_lead
);

  logic            in_acc;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  item_t           fr_item;
  item_t           q_item;
  logic [CpW-1:0]  cp;
  logic [LenW-1:0] len;

  // front takes a byte whenever the queue has room
  assign s_axis_tready_o = !q_full;
  assign in_acc          = s_axis_tvalid_i && !q_full;

  u8dec_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .byte_i   (s_axis_tdata_i),
    .item_o   (fr_item)
  );

  u8dec_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .item_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  u8dec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cp_o        (cp),
    .len_o       (len),
    .bad_o       (m_axis_tuser_o)
  );

  // pack character code lowest, length above it
  assign m_axis_tdata_o = {len, cp};

endmodule
